### rtl/hdsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Half-duplex soft UART package
// Types, constants and codes shared by the UART core, its register file and
// its checker.
// ----------------------------------------------------------------------------
package hdsu_pkg;

	localparam int DATA_BITS   = 8;
	localparam int FRAME_BITS  = DATA_BITS + 2;
	localparam int TIMER_WIDTH = 16;
	localparam int DATA_IDX_W  = $clog2(DATA_BITS);
	localparam int FRAME_IDX_W = $clog2(FRAME_BITS);
	localparam int BIT_IDX_W   = $clog2(FRAME_BITS + 1);
	localparam int REG_COUNT   = 6;
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;

	localparam logic [DATA_BITS-1:0] NO_BYTE = '1;

	// Register indexes (word offsets on the configuration port).
	localparam logic [2:0] REG_IDLE_POLL    = 3'd0;
	localparam logic [2:0] REG_FIRST_SAMPLE = 3'd1;
	localparam logic [2:0] REG_RX_BIT       = 3'd2;
	localparam logic [2:0] REG_TX_START     = 3'd3;
	localparam logic [2:0] REG_TX_BIT       = 3'd4;
	localparam logic [2:0] REG_TX_END       = 3'd5;

	// Register reset values.
	localparam logic [TIMER_WIDTH-1:0] RST_IDLE_POLL    = TIMER_WIDTH'(200);
	localparam logic [TIMER_WIDTH-1:0] RST_FIRST_SAMPLE = TIMER_WIDTH'(1234);
	localparam logic [TIMER_WIDTH-1:0] RST_RX_BIT       = TIMER_WIDTH'(833);
	localparam logic [TIMER_WIDTH-1:0] RST_TX_START     = TIMER_WIDTH'(833);
	localparam logic [TIMER_WIDTH-1:0] RST_TX_BIT       = TIMER_WIDTH'(833);
	localparam logic [TIMER_WIDTH-1:0] RST_TX_END       = TIMER_WIDTH'(100);

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_SEND = 2'd1,
		CMD_READ = 2'd2
	} hdsu_cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RX   = 2'd1,
		MODE_TX   = 2'd2
	} hdsu_mode_t;

	typedef enum logic [1:0] {
		RXS_EMPTY = 2'd0,
		RXS_READY = 2'd1,
		RXS_BUSY  = 2'd2
	} hdsu_rx_status_t;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [DATA_BITS-1:0] tx_byte;
		logic                 rx_level;
	} hdsu_in_t;

	typedef struct packed {
		logic                 tx_level;
		logic                 send_accepted;
		logic [DATA_BITS-1:0] rx_byte;
		logic                 rx_valid;
		logic [1:0]           line_state;
	} hdsu_out_t;

	typedef struct packed {
		logic [TIMER_WIDTH-1:0] idle_poll;
		logic [TIMER_WIDTH-1:0] first_sample;
		logic [TIMER_WIDTH-1:0] rx_bit;
		logic [TIMER_WIDTH-1:0] tx_start;
		logic [TIMER_WIDTH-1:0] tx_bit;
		logic [TIMER_WIDTH-1:0] tx_end;
	} hdsu_intervals_t;

endpackage

### rtl/half_duplex_soft_uart_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Half-duplex soft UART core
// 8N2 UART driven by tick, send and read command words, with one shared
// line state, bit counter and interval timer, and APB-style interval registers.
// ----------------------------------------------------------------------------
// Response: the result for a command word is registered when the word is
// accepted and presented in the cycle after.
// Throughput: one word per cycle while responses are taken; the line engine
// updates its state as the word is accepted, so the next may follow at once.
// Reset: arst_n resets the line state, timer and response valid flag at once
// but not the payload; the interval registers return to their documented defaults.
// ----------------------------------------------------------------------------
module half_duplex_soft_uart_core (
	input  logic                         clk,
	input  logic                         arst_n,

	// Command channel.
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  hdsu_pkg::hdsu_in_t           cmd_word,

	// Response channel.
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output hdsu_pkg::hdsu_out_t          rsp_word,

	// Configuration port.
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hdsu_pkg::PADDR_W-1:0] paddr,
	input  logic [hdsu_pkg::PDATA_W-1:0] pwdata,
	output logic [hdsu_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import hdsu_pkg::*;

	hdsu_intervals_t intervals;
	hdsu_out_t       result;
	hdsu_out_t       rsp_word_q;
	logic            rsp_valid_q;
	logic            accept;

	// The register file never stalls the bus.
	assign pready = 1'b1;

	hdsu_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.intervals (intervals)
	);

	// A new word is taken whenever the result register is empty or its
	// contents are being taken in the same cycle, so the block keeps a full
	// word-per-cycle rate while the consumer keeps up.
	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign accept    = cmd_valid && cmd_ready;

	// The engine commits its state only on an accepted word; its result is
	// the combinational outcome of that word and is captured below.
	hdsu_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept),
		.word      (cmd_word),
		.intervals (intervals),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd_ready) begin
			rsp_valid_q <= cmd_valid;
		end
	end

	// Payload needs no reset: it is only looked at while valid is high.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_word_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

endmodule

### rtl/hdsu_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Half-duplex soft UART interval registers
// APB-style register file holding the six timer reload intervals.
// ----------------------------------------------------------------------------
module hdsu_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hdsu_pkg::PADDR_W-1:0]      paddr,
	input  logic [hdsu_pkg::PDATA_W-1:0]      pwdata,
	output logic [hdsu_pkg::PDATA_W-1:0]      prdata,
	output hdsu_pkg::hdsu_intervals_t         intervals
);
	import hdsu_pkg::*;

	hdsu_intervals_t regs_q;
	logic            wr_en;
	logic [2:0]      reg_idx;
	logic [TIMER_WIDTH-1:0] wr_val;
	logic [TIMER_WIDTH-1:0] rd_val;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_val  = pwdata[TIMER_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.idle_poll    <= RST_IDLE_POLL;
			regs_q.first_sample <= RST_FIRST_SAMPLE;
			regs_q.rx_bit       <= RST_RX_BIT;
			regs_q.tx_start     <= RST_TX_START;
			regs_q.tx_bit       <= RST_TX_BIT;
			regs_q.tx_end       <= RST_TX_END;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_IDLE_POLL:    regs_q.idle_poll    <= wr_val;
				REG_FIRST_SAMPLE: regs_q.first_sample <= wr_val;
				REG_RX_BIT:       regs_q.rx_bit       <= wr_val;
				REG_TX_START:     regs_q.tx_start     <= wr_val;
				REG_TX_BIT:       regs_q.tx_bit       <= wr_val;
				REG_TX_END:       regs_q.tx_end       <= wr_val;
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_IDLE_POLL:    rd_val = regs_q.idle_poll;
			REG_FIRST_SAMPLE: rd_val = regs_q.first_sample;
			REG_RX_BIT:       rd_val = regs_q.rx_bit;
			REG_TX_START:     rd_val = regs_q.tx_start;
			REG_TX_BIT:       rd_val = regs_q.tx_bit;
			REG_TX_END:       rd_val = regs_q.tx_end;
			default:          rd_val = '0;
		endcase
	end

	assign prdata    = PDATA_W'(rd_val);
	assign intervals = regs_q;

endmodule

### rtl/hdsu_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Half-duplex soft UART line engine
// Holds the shared line state, bit counter and interval timer, and works out
// the next state and the result for one word in a single pass.
// ----------------------------------------------------------------------------
module hdsu_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  hdsu_pkg::hdsu_in_t        word,
	input  hdsu_pkg::hdsu_intervals_t intervals,
	output hdsu_pkg::hdsu_out_t       result
);
	import hdsu_pkg::*;

	hdsu_mode_t             mode_q, mode_d;
	logic [BIT_IDX_W-1:0]   bit_q, bit_d;
	logic [FRAME_BITS-1:0]  frame_q, frame_d;
	logic [DATA_BITS-1:0]   shift_q, shift_d;
	hdsu_rx_status_t        status_q, status_d;
	logic [TIMER_WIDTH-1:0] count_q, count_d;
	logic                   line_q, line_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			bit_q    <= '0;
			frame_q  <= '0;
			shift_q  <= '0;
			status_q <= RXS_EMPTY;
			count_q  <= RST_IDLE_POLL;
			line_q   <= 1'b1;
		end else if (step) begin
			mode_q   <= mode_d;
			bit_q    <= bit_d;
			frame_q  <= frame_d;
			shift_q  <= shift_d;
			status_q <= status_d;
			count_q  <= count_d;
			line_q   <= line_d;
		end
	end

	always_comb begin
		mode_d   = mode_q;
		bit_d    = bit_q;
		frame_d  = frame_q;
		shift_d  = shift_q;
		status_d = status_q;
		count_d  = count_q;
		line_d   = line_q;

		result.send_accepted = 1'b0;
		result.rx_byte       = NO_BYTE;
		result.rx_valid      = 1'b0;

		unique case (word.cmd)
			CMD_TICK: begin
				if (count_q > TIMER_WIDTH'(1)) begin
					count_d = count_q - 1'b1;
				end else begin
					// The interval has run out: act on the line state.
					unique case (mode_q)
						MODE_IDLE: begin
							if (!word.rx_level) begin
								status_d = RXS_BUSY;
								count_d  = intervals.first_sample;
								mode_d   = MODE_RX;
								shift_d  = '0;
							end else begin
								count_d = intervals.idle_poll;
							end
							bit_d = '0;
						end
						MODE_RX: begin
							if (bit_q < BIT_IDX_W'(DATA_BITS)) begin
								count_d = intervals.rx_bit;
								shift_d[bit_q[DATA_IDX_W-1:0]] = word.rx_level;
								bit_d = bit_q + 1'b1;
							end else begin
								// Stop bit is not checked.
								mode_d   = MODE_IDLE;
								count_d  = intervals.idle_poll;
								status_d = RXS_READY;
								bit_d    = '0;
							end
						end
						MODE_TX: begin
							if (bit_q < BIT_IDX_W'(FRAME_BITS)) begin
								line_d  = frame_q[bit_q[FRAME_IDX_W-1:0]];
								bit_d   = bit_q + 1'b1;
								count_d = intervals.tx_bit;
							end else begin
								mode_d  = MODE_IDLE;
								bit_d   = '0;
								count_d = intervals.tx_end;
							end
						end
						default: mode_d = MODE_IDLE;
					endcase
				end
			end
			CMD_SEND: begin
				if (mode_q == MODE_IDLE) begin
					frame_d = {2'b11, word.tx_byte};
					count_d = intervals.tx_start;
					mode_d  = MODE_TX;
					line_d  = 1'b0;
					bit_d   = '0;
					result.send_accepted = 1'b1;
				end
			end
			CMD_READ: begin
				if (status_q == RXS_READY) begin
					result.rx_byte  = shift_q;
					result.rx_valid = 1'b1;
					status_d        = RXS_EMPTY;
				end
			end
			default: ;
		endcase

		result.tx_level   = line_d;
		result.line_state = 2'(mode_d);
	end

endmodule

### rtl/hdsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Half-duplex soft UART port checker
// Concurrent assertions on the core's ports, bound to the top level.
// ----------------------------------------------------------------------------
module hdsu_port_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input hdsu_pkg::hdsu_out_t rsp_word
);
	import hdsu_pkg::*;

	// A stalled response holds its word.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
		else $error("stalled response word changed");

	// Every accepted command word yields a response on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> rsp_valid)
		else $error("accepted command word gave no response");

	// A taken send leaves the block transmitting with the start bit low.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.send_accepted |->
			!rsp_word.tx_level && rsp_word.line_state == 2'(MODE_TX))
		else $error("accepted send without start bit");

	// A response without a fresh byte carries the empty marker and no grant
	// clashes with a read result.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_word.rx_valid |-> rsp_word.rx_byte == NO_BYTE)
		else $error("byte reported without valid flag");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_word.rx_valid && rsp_word.send_accepted))
		else $error("read and send results in one word");

endmodule

bind half_duplex_soft_uart_core hdsu_port_checker u_hdsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_word  (rsp_word)
);

### dv/hdsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Half-duplex soft UART checker
// Watches the command, response and configuration ports of the UART core,
// predicts every response word from its own copy of the line engine and
// compares each field against what the core returns.
// ----------------------------------------------------------------------------
module hdsu_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  logic                         cmd_ready,
	input  hdsu_pkg::hdsu_in_t           cmd_word,
	input  logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  hdsu_pkg::hdsu_out_t          rsp_word,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [hdsu_pkg::PADDR_W-1:0] paddr,
	input  logic [hdsu_pkg::PDATA_W-1:0] pwdata,
	output int                           fail_count,
	output int                           pending
);

	import hdsu_pkg::*;

	// Predicted line engine state and interval registers.
	hdsu_intervals_t        intervals;
	hdsu_mode_t             line_mode;
	hdsu_rx_status_t        rx_status;
	logic [BIT_IDX_W-1:0]   bit_index;
	logic [FRAME_BITS-1:0]  tx_frame;
	logic [DATA_BITS-1:0]   rx_shift;
	logic [TIMER_WIDTH-1:0] interval_count;
	logic                   tx_line;

	hdsu_out_t expected_replies[$];
	hdsu_out_t want;

	// Advances the line engine by one command word and returns its reply.
	function automatic hdsu_out_t step_line(input hdsu_in_t w);
		hdsu_out_t r;
		r.send_accepted = 1'b0;
		r.rx_byte       = NO_BYTE;
		r.rx_valid      = 1'b0;
		case (w.cmd)
			CMD_TICK: begin
				if (interval_count > 1) begin
					interval_count = interval_count - 1'b1;
				end else begin
					// A count of one or zero expires; zero reloads behave as one.
					case (line_mode)
						MODE_IDLE: begin
							if (!w.rx_level) begin
								rx_status      = RXS_BUSY;
								interval_count = intervals.first_sample;
								line_mode      = MODE_RX;
								rx_shift       = '0;
							end else begin
								interval_count = intervals.idle_poll;
							end
							bit_index = '0;
						end
						MODE_RX: begin
							if (bit_index < DATA_BITS) begin
								interval_count = intervals.rx_bit;
								rx_shift[bit_index[DATA_IDX_W-1:0]] = w.rx_level;
								bit_index      = bit_index + 1'b1;
							end else begin
								// The stop bit is not checked.
								line_mode      = MODE_IDLE;
								interval_count = intervals.idle_poll;
								rx_status      = RXS_READY;
								bit_index      = '0;
							end
						end
						MODE_TX: begin
							if (bit_index < FRAME_BITS) begin
								tx_line        = tx_frame[bit_index];
								bit_index      = bit_index + 1'b1;
								interval_count = intervals.tx_bit;
							end else begin
								line_mode      = MODE_IDLE;
								bit_index      = '0;
								interval_count = intervals.tx_end;
							end
						end
						default: line_mode = MODE_IDLE;
					endcase
				end
			end
			CMD_SEND: begin
				if (line_mode == MODE_IDLE) begin
					tx_frame        = {2'b11, w.tx_byte};
					interval_count  = intervals.tx_start;
					line_mode       = MODE_TX;
					tx_line         = 1'b0;
					bit_index       = '0;
					r.send_accepted = 1'b1;
				end
			end
			CMD_READ: begin
				if (rx_status == RXS_READY) begin
					r.rx_byte  = rx_shift;
					r.rx_valid = 1'b1;
					rx_status  = RXS_EMPTY;
				end
			end
			default: ;
		endcase
		r.tx_level   = tx_line;
		r.line_state = line_mode;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] expected_value,
			input logic [7:0] actual_value);
		if (actual_value !== expected_value) begin
			$error("%s: expected %0h, actual %0h", name, expected_value, actual_value);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intervals      = {RST_IDLE_POLL, RST_FIRST_SAMPLE, RST_RX_BIT,
				RST_TX_START, RST_TX_BIT, RST_TX_END};
			line_mode      = MODE_IDLE;
			rx_status      = RXS_EMPTY;
			bit_index      = '0;
			tx_frame       = '0;
			rx_shift       = '0;
			interval_count = RST_IDLE_POLL;
			tx_line        = 1'b1;
			fail_count     = 0;
			expected_replies.delete();
			pending <= 0;
		end else begin
			// Replies are taken first: a word accepted now cannot be answered now.
			if (rsp_valid && rsp_ready) begin
				if (expected_replies.size() == 0) begin
					$error("reply word received with nothing expected");
					fail_count++;
				end else begin
					want = expected_replies.pop_front();
					compare_field("tx_level", 8'(want.tx_level), 8'(rsp_word.tx_level));
					compare_field("send_accepted", 8'(want.send_accepted),
						8'(rsp_word.send_accepted));
					compare_field("rx_byte", want.rx_byte, rsp_word.rx_byte);
					compare_field("rx_valid", 8'(want.rx_valid), 8'(rsp_word.rx_valid));
					compare_field("line_state", 8'(want.line_state), 8'(rsp_word.line_state));
				end
			end
			if (cmd_valid && cmd_ready)
				expected_replies.push_back(step_line(cmd_word));
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_IDLE_POLL:    intervals.idle_poll    = pwdata[TIMER_WIDTH-1:0];
					REG_FIRST_SAMPLE: intervals.first_sample = pwdata[TIMER_WIDTH-1:0];
					REG_RX_BIT:       intervals.rx_bit       = pwdata[TIMER_WIDTH-1:0];
					REG_TX_START:     intervals.tx_start     = pwdata[TIMER_WIDTH-1:0];
					REG_TX_BIT:       intervals.tx_bit       = pwdata[TIMER_WIDTH-1:0];
					REG_TX_END:       intervals.tx_end       = pwdata[TIMER_WIDTH-1:0];
					default: ;
				endcase
			end
			pending <= expected_replies.size();
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Half-duplex soft UART testbench
// Drives tick, send, read and unused command words into the UART core under
// a series of interval settings, with random gaps on the command side and
// random stalls on the response side. A checker beside the core predicts and
// compares every response word; this module only makes stimulus and decides
// the verdict.
// ----------------------------------------------------------------------------
module testbench;

	import hdsu_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 5;
	localparam int MAX_WAIT      = 14;
	localparam int STALL_LIMIT   = 500;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES        = 13;
	localparam int PHASE_WORDS   = 100;
	localparam int FULL_WORDS    = 60;
	localparam int ZERO_PHASE    = 1;
	localparam int FULL_PHASE    = PHASES;
	localparam int LINE_IDLE     = FRAME_BITS;

	// The command field is two bits wide; its fourth code does nothing.
	localparam logic [1:0]           CMD_UNUSED  = 2'd3;
	localparam logic [DATA_BITS-1:0] SAMPLE_BYTE = 8'hA5;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_ready;
	hdsu_in_t             cmd_word  = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	hdsu_out_t            rsp_word;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [PADDR_W-1:0]   paddr     = '0;
	logic [PDATA_W-1:0]   pwdata    = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	int                   fail_count;
	int                   pending;
	int                   idle_cycles = 0;

	// When calm is set neither side idles, giving stretches at full rate.
	bit                   calm = 1'b0;

	// Interval values for the next phase, indexed by register number.
	logic [TIMER_WIDTH-1:0] ticks_cfg [REG_COUNT];

	// A simple serial sender on the receive line: it plays a start bit, eight
	// data bits and a stop bit, each held for one receive bit period of ticks.
	logic [FRAME_BITS-1:0]  line_frame = '1;
	int                     line_bit   = LINE_IDLE;
	int                     line_left  = 0;
	int                     line_ticks = 1;

	always #HALF_PERIOD clk = ~clk;

	half_duplex_soft_uart_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_word  (cmd_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	hdsu_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd_word   (cmd_word),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp_word   (rsp_word),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// One register write: a setup phase, then an access phase. The select is
	// left high so that writes can follow each other without a gap; the
	// caller lowers it after the last one. The upper data bits carry noise,
	// which the core is expected to ignore.
	task automatic apb_write(input int index, input logic [TIMER_WIDTH-1:0] value);
		logic [PDATA_W-1:0] bus;
		bus = $urandom;
		bus[TIMER_WIDTH-1:0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(index * 4);
		pwdata  <= bus;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	// Offers one command word after a random gap and returns at the edge at
	// which it is accepted. Valid is left high so that a word with no gap
	// follows straight on; it is only lowered when a gap is drawn.
	task automatic put_word(input logic [1:0] code, input logic [DATA_BITS-1:0] data,
			input logic level);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word  <= {code, data, level};
		do @(posedge clk); while (!cmd_ready);
	endtask

	// Stops sending and waits until every expected reply word has come back.
	task automatic drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Loads the six interval registers from ticks_cfg while nothing is in
	// flight, then writes to an index past the last register, which must be
	// ignored. Each phase also decides whether both sides run without gaps.
	task automatic load_intervals();
		drain();
		for (int i = 0; i < REG_COUNT; i++)
			apb_write(i, ticks_cfg[i]);
		apb_write(REG_COUNT + $urandom_range(0, 1), TIMER_WIDTH'($urandom));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		line_ticks = (ticks_cfg[REG_RX_BIT] == 0) ? 1 : int'(ticks_cfg[REG_RX_BIT]);
		calm = ($urandom_range(0, 3) == 0);
	endtask

	// Response side: before each reply word it draws a stall, holds ready
	// low for that many cycles, then waits with ready high for the handshake.
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// Watchdog: any accepted word or register access restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) ||
				(psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int pick;
		int words;
		logic level;
		logic [DATA_BITS-1:0] data;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Under the reset intervals: the unused command and a read with
		// nothing received, both of which must leave the state alone.
		put_word(CMD_UNUSED, 8'hFF, 1'b1);
		put_word(CMD_READ, 8'h00, 1'b0);

		// With every interval at one, each tick expires the timer, so a whole
		// frame goes by in a handful of words.
		foreach (ticks_cfg[i]) ticks_cfg[i] = TIMER_WIDTH'(1);
		load_intervals();

		// A send from idle is taken and drives the start bit; a second send
		// while transmitting is refused.
		put_word(CMD_SEND, 8'hFF, 1'b0);
		put_word(CMD_SEND, 8'h00, 1'b1);

		// Ten frame bits, then one more tick to return to idle polling.
		for (int i = 0; i < FRAME_BITS + 1; i++)
			put_word(CMD_TICK, 8'($urandom), i[0]);

		// A low level at the poll starts a receive; a send now is refused.
		put_word(CMD_TICK, 8'h00, 1'b0);
		put_word(CMD_SEND, 8'h5A, 1'b1);
		for (int i = 0; i < DATA_BITS; i++)
			put_word(CMD_TICK, 8'($urandom), SAMPLE_BYTE[i]);

		// The tick after the eighth sample marks the byte ready without
		// looking at the stop bit. The first read returns it, the second
		// finds nothing, and a send right after the receive is taken.
		put_word(CMD_TICK, 8'h00, 1'b1);
		put_word(CMD_READ, 8'h00, 1'b1);
		put_word(CMD_READ, 8'hFF, 1'b0);
		put_word(CMD_SEND, 8'h00, 1'b1);

		// Random phases. Most use short intervals so that frames complete
		// often; one uses zero everywhere (which must act as one), and the
		// last uses the largest value, after which little can expire.
		for (int phase = 0; phase <= PHASES; phase++) begin
			foreach (ticks_cfg[i]) begin
				if (phase == ZERO_PHASE)
					ticks_cfg[i] = '0;
				else if (phase == FULL_PHASE)
					ticks_cfg[i] = '1;
				else if ($urandom_range(0, 5) == 0)
					ticks_cfg[i] = TIMER_WIDTH'($urandom_range(9, 40));
				else
					ticks_cfg[i] = TIMER_WIDTH'($urandom_range(1, 8));
			end
			load_intervals();
			words = (phase == FULL_PHASE) ? FULL_WORDS : PHASE_WORDS;

			for (int n = 0; n < words; n++) begin
				pick = $urandom_range(0, 99);
				data = DATA_BITS'($urandom);
				if (pick < 72) begin
					// Ticks carry the serial sender's level, now and then
					// with a glitch so that the receiver also sees noise.
					if (line_bit == LINE_IDLE && $urandom_range(0, 5) == 0) begin
						line_frame = {1'b1, data, 1'b0};
						line_bit   = 0;
						line_left  = line_ticks;
					end
					level = (line_bit == LINE_IDLE) ? 1'b1 : line_frame[line_bit];
					if (line_bit != LINE_IDLE) begin
						line_left--;
						if (line_left == 0) begin
							line_bit++;
							line_left = line_ticks;
						end
					end
					if ($urandom_range(0, 9) == 0)
						level = ~level;
					put_word(CMD_TICK, data, level);
				end else if (pick < 82) begin
					put_word(CMD_SEND, data, 1'($urandom));
				end else if (pick < 96) begin
					put_word(CMD_READ, data, 1'($urandom));
				end else begin
					put_word(CMD_UNUSED, data, 1'($urandom));
				end
			end
		end

		// Wait for the last replies, then let the core settle so that any
		// stray reply word would be caught by the checker.
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

### half_duplex_soft_uart_core.f
rtl/hdsu_pkg.sv
rtl/hdsu_regs.sv
rtl/hdsu_engine.sv
rtl/half_duplex_soft_uart_core.sv
rtl/hdsu_checker.sv
dv/hdsu_checker.sv
dv/testbench.sv
